// ----- hw/rtl/crc16fc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fc_pkg
// Shared types, register indexes and the byte-wise CRC-16/CCITT update.
// ----------------------------------------------------------------------------
package crc16fc_pkg;

	localparam int unsigned CfgIdxW   = 1;
	localparam int unsigned CfgDataW  = 16;
	localparam int unsigned InDataW   = 8;
	localparam int unsigned OutDataW  = 24;

	localparam logic [CfgIdxW-1:0] CFG_CRC_INITIAL = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_CHECK_MODE  = 1'b1;

	localparam logic [7:0] PAD_BYTE = 8'h00;

	// result of one frame, core -> output register
	typedef struct packed {
		logic        valid;
		logic [15:0] crc;
		logic        match;
	} crc_result_t;

	// shift form of poly 0x1021, one byte per call, no reflection
	function automatic logic [15:0] crc_update(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = {c_in[7:0], c_in[15:8]};
		c[7:0] = c[7:0] ^ b;
		c = c ^ {12'h000, c[7:4]};
		c = c ^ {c[3:0], 12'h000};
		c = c ^ {3'b000, c[7:0], 5'b00000};
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/crc16_frame_calc_check.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_frame_calc_check
// Streaming CRC-16/CCITT over frames, calc or trailer-check mode.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, except that a frame's last byte waits while
//   an unaccepted result is held; the CRC byte update is combinational.
// Result path: last byte in the input register, then its CRC in the result register.
// Reset: arst_n clears config to zero, empties both registers and arms
//   the next byte as the start of a frame.
module crc16_frame_calc_check (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                cfg_we,
	input  wire logic [crc16fc_pkg::CfgIdxW-1:0]     cfg_addr,
	input  wire logic [crc16fc_pkg::CfgDataW-1:0]    cfg_wdata,
	// input stream
	input  wire logic                                s_axis_tvalid,
	output      logic                                s_axis_tready,
	input  wire logic [crc16fc_pkg::InDataW-1:0]     s_axis_tdata,  // [7:0] data_byte
	input  wire logic                                s_axis_tlast,  // last_byte
	// result stream
	output      logic                                m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output      logic [crc16fc_pkg::OutDataW-1:0]    m_axis_tdata   // [15:0] crc_value,
	                                                                // [16] crc_match, zeros
);

	logic [15:0] crc_initial_q;
	logic        check_mode_q;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        advance;

	logic        out_valid_q;
	logic [15:0] out_crc_q;
	logic        out_match_q;

	crc16fc_pkg::crc_result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_initial_q <= 16'h0000;
			check_mode_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				crc16fc_pkg::CFG_CRC_INITIAL: crc_initial_q <= cfg_wdata;
				crc16fc_pkg::CFG_CHECK_MODE:  check_mode_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// non-final bytes never wait on the result side
	assign advance       = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata[7:0];
			last_s1 <= s_axis_tlast;
		end
	end

	crc16fc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.data_byte   (data_s1),
		.last_byte   (last_s1),
		.crc_initial (crc_initial_q),
		.check_mode  (check_mode_q),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			out_crc_q   <= result.crc;
			out_match_q <= result.match;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0000000, out_match_q, out_crc_q};

endmodule
`default_nettype wire

// ----- hw/rtl/crc16fc_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fc_core
// Frame state and per-byte CRC update; one byte per cycle when advanced.
// ----------------------------------------------------------------------------
module crc16fc_core (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     advance,
	input  wire logic [7:0]               data_byte,
	input  wire logic                     last_byte,
	input  wire logic [15:0]              crc_initial,
	input  wire logic                     check_mode,
	output crc16fc_pkg::crc_result_t      result
);

	logic        frame_start_q;
	logic [15:0] crc_q;
	logic        parity_q;
	logic [7:0]  held0_q;
	logic [7:0]  held1_q;
	logic [1:0]  held_cnt_q;

	logic [15:0] crc_b;
	logic        par_b;
	logic [7:0]  h0_b;
	logic [7:0]  h1_b;
	logic [1:0]  cnt_b;
	logic        had_two;
	logic [15:0] crc_c1;
	logic        par_c1;
	logic [7:0]  h0_n;
	logic [7:0]  h1_n;
	logic [1:0]  cnt_n;
	logic [15:0] crc_c2;
	logic        par_c2;
	logic        match;

	always_comb begin
		// frame start reloads the initial value and drops held bytes
		crc_b = frame_start_q ? crc_initial : crc_q;
		par_b = frame_start_q ? 1'b0 : parity_q;
		h0_b  = frame_start_q ? 8'h00 : held0_q;
		h1_b  = frame_start_q ? 8'h00 : held1_q;
		cnt_b = frame_start_q ? 2'd0 : held_cnt_q;

		had_two = 1'b0;
		crc_c1  = crc_b;
		par_c1  = par_b;
		h0_n    = h0_b;
		h1_n    = h1_b;
		cnt_n   = cnt_b;
		if (check_mode) begin
			had_two = (cnt_b == 2'd2);
			if (had_two) begin
				crc_c1 = crc16fc_pkg::crc_update(crc_b, h0_b);
				par_c1 = ~par_b;
				h0_n   = h1_b;
				h1_n   = data_byte;
			end else if (cnt_b == 2'd1) begin
				h1_n  = data_byte;
				cnt_n = 2'd2;
			end else begin
				h0_n  = data_byte;
				cnt_n = 2'd1;
			end
		end else begin
			crc_c1 = crc16fc_pkg::crc_update(crc_b, data_byte);
			par_c1 = ~par_b;
		end

		// odd covered count gets a zero pad on the final byte
		crc_c2 = crc_c1;
		par_c2 = par_c1;
		if (last_byte && par_c1) begin
			crc_c2 = crc16fc_pkg::crc_update(crc_c1, crc16fc_pkg::PAD_BYTE);
			par_c2 = 1'b0;
		end

		match = check_mode && had_two && (crc_c2[7:0] == h0_n) && (crc_c2[15:8] == h1_n);

		result.valid = advance && last_byte;
		result.crc   = crc_c2;
		result.match = match;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_start_q <= 1'b1;
			crc_q         <= 16'h0000;
			parity_q      <= 1'b0;
			held0_q       <= 8'h00;
			held1_q       <= 8'h00;
			held_cnt_q    <= 2'd0;
		end else if (advance) begin
			frame_start_q <= last_byte;
			crc_q         <= crc_c2;
			parity_q      <= par_c2;
			held0_q       <= h0_n;
			held1_q       <= h1_n;
			held_cnt_q    <= cnt_n;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/crc16fc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fc_checker
// Port-level checks: result handshake and frame/result bookkeeping.
// ----------------------------------------------------------------------------
module crc16fc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        s_axis_tlast,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata
);

	// frames whose last byte went in but whose result is not yet out
	logic [2:0] pending_q;
	logic       in_last;
	logic       out_xfer;

	assign in_last  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else begin
			pending_q <= pending_q + {2'b00, in_last} - {2'b00, out_xfer};
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result data changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != 3'd0)
		else $error("result transfer without a finished frame");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd2)
		else $error("more finished frames in flight than storage");

endmodule

bind crc16_frame_calc_check crc16fc_checker u_crc16fc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for crc16_frame_calc_check. Directed frames, then random
// frames under random valid/ready gaps, run in calc and trailer-check mode. A
// scoreboard predicts the CRC and match flag of every frame and checks each
// result transfer against them.
// ----------------------------------------------------------------------------
module tb;

	localparam int STALL_LIMIT = 1000;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic [15:0] crc;
		logic        match;
	} frame_result_t;

	class crc_frame_scoreboard;
		logic [15:0]   crc_seed;
		logic          verify_mode;
		logic [15:0]   crc_acc;
		bit            new_frame;
		bit            odd_covered;
		logic [7:0]    trailer[2];
		int unsigned   trailer_cnt;
		frame_result_t crc_due_q[$];
		int unsigned   errors;

		function new();
			crc_seed    = '0;
			verify_mode = 1'b0;
			crc_acc     = '0;
			new_frame   = 1'b1;
			odd_covered = 1'b0;
			trailer[0]  = '0;
			trailer[1]  = '0;
			trailer_cnt = 0;
			errors      = 0;
		endfunction

		// MSB-first shift register form of poly 0x1021
		static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			r = c ^ {b, 8'h00};
			for (int i = 0; i < 8; i++)
				r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
			return r;
		endfunction

		function void fold(logic [7:0] b);
			crc_acc     = crc_byte(crc_acc, b);
			odd_covered = ~odd_covered;
		endfunction

		function void write_reg(logic [crc16fc_pkg::CfgIdxW-1:0] idx,
			logic [crc16fc_pkg::CfgDataW-1:0] val);
			if (idx == crc16fc_pkg::CFG_CRC_INITIAL)
				crc_seed = val;
			else if (idx == crc16fc_pkg::CFG_CHECK_MODE)
				verify_mode = val[0];
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			bit            had_two;
			frame_result_t res;
			had_two   = 1'b0;
			res.match = 1'b0;
			if (new_frame) begin
				crc_acc     = crc_seed;
				odd_covered = 1'b0;
				trailer_cnt = 0;
				trailer[0]  = '0;
				trailer[1]  = '0;
				new_frame   = 1'b0;
			end
			if (verify_mode) begin
				// last two bytes stay out of the CRC until pushed out by newer ones
				had_two = (trailer_cnt >= 2);
				if (had_two) begin
					fold(trailer[0]);
					trailer[0] = trailer[1];
					trailer[1] = b;
				end else if (trailer_cnt == 1) begin
					trailer[1]  = b;
					trailer_cnt = 2;
				end else begin
					trailer[0]  = b;
					trailer_cnt = 1;
				end
				if (last) begin
					if (odd_covered)
						fold(crc16fc_pkg::PAD_BYTE);
					res.match = had_two && (crc_acc[7:0] == trailer[0])
						&& (crc_acc[15:8] == trailer[1]);
				end
			end else begin
				fold(b);
				if (last && odd_covered)
					fold(crc16fc_pkg::PAD_BYTE);
			end
			if (last) begin
				res.crc = crc_acc;
				crc_due_q.push_back(res);
				new_frame = 1'b1;
			end
		endfunction

		function void check_result(logic [crc16fc_pkg::OutDataW-1:0] d);
			frame_result_t want;
			if (crc_due_q.size() == 0) begin
				$error("unexpected result transfer, crc_value %h", d[15:0]);
				errors++;
				return;
			end
			want = crc_due_q.pop_front();
			if (d[15:0] !== want.crc) begin
				$error("crc_value: expected %h, actual %h", want.crc, d[15:0]);
				errors++;
			end
			if (d[16] !== want.match) begin
				$error("crc_match: expected %b, actual %b", want.match, d[16]);
				errors++;
			end
			if (d[crc16fc_pkg::OutDataW-1:17] !== '0) begin
				$error("tdata pad: expected 0, actual %h", d[crc16fc_pkg::OutDataW-1:17]);
				errors++;
			end
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_we;
	logic [crc16fc_pkg::CfgIdxW-1:0]     cfg_addr;
	logic [crc16fc_pkg::CfgDataW-1:0]    cfg_wdata;
	logic                                s_valid;
	wire                                 s_axis_tready;
	logic [crc16fc_pkg::InDataW-1:0]     s_data;
	logic                                s_last;
	wire                                 m_axis_tvalid;
	logic                                m_ready;
	wire  [crc16fc_pkg::OutDataW-1:0]    m_axis_tdata;

	crc_frame_scoreboard sb;
	int          s_gap_max = 0;
	int          m_gap_max = 0;
	int unsigned items_sent = 0;
	int          stall_cycles = 0;

	crc16_frame_calc_check u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_data),
		.s_axis_tlast  (s_last),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// CRC of a payload as the checker computes it, zero pad on odd length
	function automatic logic [15:0] payload_crc(logic [15:0] seed, byte_q_t p);
		logic [15:0] c;
		c = seed;
		foreach (p[i])
			c = crc_frame_scoreboard::crc_byte(c, p[i]);
		if (p.size() % 2)
			c = crc_frame_scoreboard::crc_byte(c, crc16fc_pkg::PAD_BYTE);
		return c;
	endfunction

	function automatic byte_q_t with_trailer(byte_q_t p);
		logic [15:0] c;
		c = payload_crc(sb.crc_seed, p);
		p.push_back(c[7:0]);
		p.push_back(c[15:8]);
		return p;
	endfunction

	function automatic byte_q_t random_frame(logic check);
		byte_q_t     p;
		int unsigned n;
		int unsigned kind;
		int unsigned idx;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		for (int i = 0; i < n; i++)
			p.push_back(8'($urandom));
		if (!check)
			return p;
		kind = $urandom_range(0, 7);
		if (kind < 5)
			return with_trailer(p);
		if (kind == 5) begin
			// corrupt one trailer bit
			p   = with_trailer(p);
			idx = $urandom_range(p.size() - 2, p.size() - 1);
			p[idx] = p[idx] ^ (8'h01 << $urandom_range(0, 7));
			return p;
		end
		if (kind == 6) begin
			p.delete();
			repeat ($urandom_range(1, 2))
				p.push_back(8'($urandom));
		end
		return p;
	endfunction

	task automatic send_byte(logic [7:0] b, logic last);
		int gap;
		gap = $urandom_range(0, s_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			s_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_valid = 1'b1;
		s_data  = b;
		s_last  = last;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic send_frame(byte_q_t f);
		foreach (f[i])
			send_byte(f[i], i == f.size() - 1);
	endtask

	// block is idle once every frame result is back and the pipe has emptied
	task automatic drain_and_pause();
		@(negedge clk);
		s_valid = 1'b0;
		while (sb.crc_due_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [crc16fc_pkg::CfgIdxW-1:0] idx,
		logic [crc16fc_pkg::CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic set_regs(logic [15:0] seed, logic mode);
		write_reg(crc16fc_pkg::CFG_CRC_INITIAL, seed);
		write_reg(crc16fc_pkg::CFG_CHECK_MODE, {15'($urandom), mode});
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (s_valid && s_axis_tready)
				sb.note_byte(s_data, s_last);
			if (m_axis_tvalid && m_ready)
				sb.check_result(m_axis_tdata);
		end
	end

	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// result side: random ready gaps per transfer
	initial begin
		int gap;
		m_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = $urandom_range(0, m_gap_max);
			@(negedge clk);
			if (gap > 0) begin
				m_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_ready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		byte_q_t     f;
		logic [15:0] seed;
		sb        = new();
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		s_valid   = 1'b0;
		s_data    = '0;
		s_last    = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset config: seed 0, calc mode
		f = {8'h00};
		send_frame(f);
		f = {8'hFF, 8'h80};
		send_frame(f);
		drain_and_pause();

		set_regs(16'hFFFF, 1'b1);
		f = {8'hA5};               // too short to hold a trailer
		send_frame(f);
		f = {8'h12, 8'h34};
		send_frame(f);
		f = {8'h7E};               // odd payload, padded
		send_frame(with_trailer(f));
		f = {8'h01, 8'hFE};
		send_frame(with_trailer(f));
		f = with_trailer(f);
		f[3] = ~f[3];
		send_frame(f);
		drain_and_pause();

		set_regs(16'h1D0F, 1'b0);
		f = {8'h31, 8'h32, 8'h33};
		send_frame(f);
		drain_and_pause();

		while (items_sent < 1600) begin
			case ($urandom_range(0, 5))
				0: seed = 16'h0000;
				1: seed = 16'hFFFF;
				default: seed = 16'($urandom);
			endcase
			s_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
			m_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
			set_regs(seed, 1'($urandom_range(0, 1)));
			repeat ($urandom_range(3, 10))
				send_frame(random_frame(sb.verify_mode));
			drain_and_pause();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.crc_due_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
